@@ hw/rtl/hhip_pkg.sv @@
`timescale 1ns / 1ps
// Package for the heading-hold incremental PID block.
// Holds field widths, fixed constants, register indexes and the control types.
// Depends on nothing; every other file of the block uses it.

package hhip_pkg;

   // Field widths.
   localparam int RATE_W   = 16;
   localparam int COEF_W   = 32;
   localparam int HALF_W   = 16;
   localparam int DUTY_W   = 16;
   localparam int DEG_W    = 10;
   localparam int HEAD_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Internal widths. While no turn is requested the error magnitude stays
   // below 2560, so 13 signed bits hold every stored error.
   localparam int ERR_W    = 13;
   localparam int DRIVE_W  = 13;
   localparam int PROD_W   = COEF_W + ERR_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int RPROD_W  = 33;
   localparam int SHIFT_W  = 24;

   // Heading is kept in 1/256 degree, coefficients in Q16.16.
   localparam int DEG_FRAC   = 8;
   localparam int COEF_FRAC  = 16;
   localparam int PERIOD_FRAC = 16;

   localparam logic [RPROD_W-1:0] TURN_LIMIT = RPROD_W'(10 << DEG_FRAC);
   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = DRIVE_W'(4000);
   localparam logic [DEG_W-1:0] DEG_MAX = '1;
   localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

   // Register reset values.
   localparam logic [HALF_W-1:0] PERIOD_RESET     = 16'd1311;
   localparam logic [DUTY_W-1:0] BASE_RIGHT_RESET = 16'd12000;
   localparam logic [DUTY_W-1:0] BASE_LEFT_RESET  = 16'd12725;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_W-1:0] REG_COEF_NOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PREV   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PREV2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_RIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_LEFT   = 3'd6;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_now;
      logic signed [COEF_W-1:0] coef_prev;
      logic signed [COEF_W-1:0] coef_prev2;
      logic signed [RATE_W-1:0] rate_offset;
      logic [HALF_W-1:0]        sample_period;
      logic [DUTY_W-1:0]        base_duty_right;
      logic [DUTY_W-1:0]        base_duty_left;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_NOW,
      MUL_PREV,
      MUL_PREV2
   } mul_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        idle;
      logic        load;
      logic        head_upd;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum_en;
      logic        finish;
   } cmd_type;

   // Status seen by the controller.
   typedef struct packed {
      logic req_fire;
      logic rsp_busy;
   } status_type;

endpackage

@@ hw/rtl/hhip_req_if.sv @@
`timescale 1ns / 1ps
// Input channel of the heading-hold PID: valid/ready plus one gyro sample.
// Depends on hhip_pkg for the field widths.

interface hhip_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hhip_pkg::RATE_W-1:0]   yaw_rate;
   logic                                 restart;

   modport source (output valid, output yaw_rate, output restart, input ready);
   modport sink   (input valid, input yaw_rate, input restart, output ready);
endinterface

@@ hw/rtl/hhip_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the heading-hold PID: valid/ready plus duties and turn request.
// Depends on hhip_pkg for the field widths.

interface hhip_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hhip_pkg::DUTY_W-1:0]  duty_right;
   logic [hhip_pkg::DUTY_W-1:0]  duty_left;
   logic                         needs_turn;
   logic                         turn_ccw;
   logic [hhip_pkg::DEG_W-1:0]   turn_degrees;

   modport source (output valid, output duty_right, output duty_left, output needs_turn,
                   output turn_ccw, output turn_degrees, input ready);
   modport sink   (input valid, input duty_right, input duty_left, input needs_turn,
                   input turn_ccw, input turn_degrees, output ready);
endinterface

@@ hw/rtl/heading_hold_incremental_pid.sv @@
`timescale 1ns / 1ps
// Top level of the heading-hold incremental PID controller.
// Depends on hhip_pkg, hhip_req_if, hhip_rsp_if, hhip_csr, hhip_ctrl and hhip_dp.
//
// Usage:
// Each item on req_ch carries one gyro yaw-rate sample and a restart flag. The
// block integrates the offset-corrected rate into a heading, runs the
// velocity-form PID on the negated heading and returns one item on rsp_ch with
// the right and left duty counts, or a turn request when the heading error has
// reached ten degrees.
// Each item passes through the idle step in which it is accepted, one heading
// update, three passes through the single shared 32x13 coefficient multiplier,
// one drive clamp and one result write; no new item is taken before then.
// The result is valid once the result write has filled the output register.
// The result sits in an output register, so the next item is accepted while a
// result is still waiting; if the receiver stalls, the following result waits
// in its final step until the register is free, and no new item is taken then.
// Reset (synchronous, active high) clears the heading, the drive history and
// the error history and returns each configuration register to its reset value.
// Configuration registers are written through csr_we, csr_idx and csr_wdata and
// should only change while no item is in flight.

module heading_hold_incremental_pid (
   input  logic                               clock,
   input  logic                               reset,
   hhip_req_if.sink                           req_ch,
   hhip_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [hhip_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [hhip_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   hhip_pkg::cfg_type    cfg;
   hhip_pkg::cmd_type    cmd;
   hhip_pkg::status_type status;
   logic                 rsp_busy;

   // Configuration register file.
   hhip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer takes an item only while idle. It looks at the request
   // only in its idle state, so the valid alone is handed over as the request.
   assign req_ch.ready    = cmd.idle;
   assign status.req_fire = req_ch.valid;
   assign status.rsp_busy = rsp_busy;

   hhip_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath owns the track state and the result register.
   hhip_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .yaw_rate (req_ch.yaw_rate),
      .restart  (req_ch.restart),
      .rsp_busy (rsp_busy),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ hw/rtl/hhip_csr.sv @@
`timescale 1ns / 1ps
// Configuration registers of the heading-hold PID, written through a plain write port.
// Depends on hhip_pkg for register indexes, reset values and cfg_type.

module hhip_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [hhip_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [hhip_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output hhip_pkg::cfg_type                  cfg
);

   hhip_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            hhip_pkg::REG_COEF_NOW:    cfg_in.coef_now        = csr_wdata;
            hhip_pkg::REG_COEF_PREV:   cfg_in.coef_prev       = csr_wdata;
            hhip_pkg::REG_COEF_PREV2:  cfg_in.coef_prev2      = csr_wdata;
            hhip_pkg::REG_RATE_OFFSET: cfg_in.rate_offset     = csr_wdata[15:0];
            hhip_pkg::REG_PERIOD:      cfg_in.sample_period   = csr_wdata[15:0];
            hhip_pkg::REG_BASE_RIGHT:  cfg_in.base_duty_right = csr_wdata[15:0];
            hhip_pkg::REG_BASE_LEFT:   cfg_in.base_duty_left  = csr_wdata[15:0];
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_now        <= '0;
         cfg_ff.coef_prev       <= '0;
         cfg_ff.coef_prev2      <= '0;
         cfg_ff.rate_offset     <= '0;
         cfg_ff.sample_period   <= hhip_pkg::PERIOD_RESET;
         cfg_ff.base_duty_right <= hhip_pkg::BASE_RIGHT_RESET;
         cfg_ff.base_duty_left  <= hhip_pkg::BASE_LEFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/hhip_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the heading-hold PID: steps one sample through the shared datapath.
// Depends on hhip_pkg for state_type, cmd_type and status_type.

module hhip_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  hhip_pkg::status_type   status,
   output hhip_pkg::cmd_type      cmd
);

   hhip_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hhip_pkg::ST_IDLE:   if (status.req_fire) state_in = hhip_pkg::ST_HEAD;
         hhip_pkg::ST_HEAD:   state_in = hhip_pkg::ST_MUL0;
         hhip_pkg::ST_MUL0:   state_in = hhip_pkg::ST_MUL1;
         hhip_pkg::ST_MUL1:   state_in = hhip_pkg::ST_MUL2;
         hhip_pkg::ST_MUL2:   state_in = hhip_pkg::ST_SUM;
         hhip_pkg::ST_SUM:    state_in = hhip_pkg::ST_FINISH;
         hhip_pkg::ST_FINISH: if (!status.rsp_busy) state_in = hhip_pkg::ST_IDLE;
         default:             state_in = hhip_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = hhip_pkg::MUL_NOW;
      unique case (state_ff)
         hhip_pkg::ST_IDLE: begin
            cmd.idle = 1'b1;
            cmd.load = status.req_fire;
         end
         hhip_pkg::ST_HEAD:   cmd.head_upd = 1'b1;
         hhip_pkg::ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hhip_pkg::MUL_NOW;
         end
         hhip_pkg::ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hhip_pkg::MUL_PREV;
         end
         hhip_pkg::ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hhip_pkg::MUL_PREV2;
         end
         hhip_pkg::ST_SUM:    cmd.sum_en = 1'b1;
         hhip_pkg::ST_FINISH: cmd.finish = !status.rsp_busy;
         default:             cmd.idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hhip_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A sample that enters must reach the heading update next.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == hhip_pkg::ST_HEAD)
      else $error("accepted sample did not start the heading update");

   // The result is only posted when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.rsp_busy)
      else $error("result posted over an unread result");

endmodule

@@ hw/rtl/hhip_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the heading-hold PID: heading integrator, shared multiplier,
// accumulator, drive clamp and the result register. Depends on hhip_pkg.

module hhip_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  hhip_pkg::cfg_type                   cfg,
   input  hhip_pkg::cmd_type                   cmd,
   input  logic signed [hhip_pkg::RATE_W-1:0]  yaw_rate,
   input  logic                                restart,
   output logic                                rsp_busy,
   hhip_rsp_if.source                          rsp_ch
);

   localparam int RATE_W  = hhip_pkg::RATE_W;
   localparam int HEAD_W  = hhip_pkg::HEAD_W;
   localparam int ERR_W   = hhip_pkg::ERR_W;
   localparam int DRIVE_W = hhip_pkg::DRIVE_W;
   localparam int PROD_W  = hhip_pkg::PROD_W;
   localparam int ACC_W   = hhip_pkg::ACC_W;
   localparam int RPROD_W = hhip_pkg::RPROD_W;
   localparam int SHIFT_W = hhip_pkg::SHIFT_W;
   localparam int DUTY_W  = hhip_pkg::DUTY_W;
   localparam int DEG_W   = hhip_pkg::DEG_W;
   localparam int SUMX_W  = ACC_W - hhip_pkg::COEF_FRAC - hhip_pkg::DEG_FRAC;
   localparam int DEL_W   = RPROD_W - hhip_pkg::PERIOD_FRAC;
   localparam int DSUM_W  = DUTY_W + 2;

   // Sample and track state.
   logic signed [RPROD_W-1:0] rprod_ff, rprod_in;
   logic                      restart_ff, restart_in;
   logic signed [HEAD_W-1:0]  heading_ff, heading_in;
   logic signed [DRIVE_W-1:0] last_drive_ff, last_drive_in;
   logic signed [ERR_W-1:0]   err_prev_ff, err_prev_in;
   logic signed [ERR_W-1:0]   err_prev2_ff, err_prev2_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]         duty_right_ff, duty_right_in;
   logic [DUTY_W-1:0]         duty_left_ff, duty_left_in;
   logic                      needs_turn_ff, needs_turn_in;
   logic                      turn_ccw_ff, turn_ccw_in;
   logic [DEG_W-1:0]          turn_deg_ff, turn_deg_in;

   // Combinational helpers.
   logic signed [RATE_W:0]     rate_diff;
   logic signed [RATE_W:0]     period_ext;
   logic signed [2*RATE_W+1:0] rate_full;
   logic signed [HEAD_W-1:0]   head_base;
   logic signed [HEAD_W:0]     head_sum;
   logic signed [HEAD_W-1:0]   neg_head;
   logic signed [ERR_W-1:0]    err_now;
   logic signed [hhip_pkg::COEF_W-1:0] mul_coef;
   logic signed [ERR_W-1:0]    mul_err;
   logic signed [PROD_W-1:0]   mul_prod;
   logic signed [SHIFT_W-1:0]  drive_sum;
   logic [HEAD_W:0]            head_mag;
   logic                       turn;
   logic [HEAD_W-hhip_pkg::DEG_FRAC:0] deg_full;
   logic signed [DSUM_W-1:0]   dr_sum;
   logic signed [DSUM_W-1:0]   dl_sum;

   assign rate_diff  = {yaw_rate[RATE_W-1], yaw_rate}
                     - {cfg.rate_offset[RATE_W-1], cfg.rate_offset};
   assign period_ext = {1'b0, cfg.sample_period};
   assign rate_full  = rate_diff * period_ext;

   assign neg_head = -heading_ff;
   assign err_now  = neg_head[ERR_W-1:0];

   // Error magnitude against the turn limit; the most negative heading needs the extra bit.
   assign head_mag = heading_ff[HEAD_W-1] ? -{heading_ff[HEAD_W-1], heading_ff}
                                          : {heading_ff[HEAD_W-1], heading_ff};
   assign turn     = head_mag >= hhip_pkg::TURN_LIMIT;
   assign deg_full = head_mag[HEAD_W:hhip_pkg::DEG_FRAC];

   always_comb begin
      unique case (cmd.mul_sel)
         hhip_pkg::MUL_NOW: begin
            mul_coef = cfg.coef_now;
            mul_err  = err_now;
         end
         hhip_pkg::MUL_PREV: begin
            mul_coef = cfg.coef_prev;
            mul_err  = err_prev_ff;
         end
         hhip_pkg::MUL_PREV2: begin
            mul_coef = cfg.coef_prev2;
            mul_err  = err_prev2_ff;
         end
         default: begin
            mul_coef = '0;
            mul_err  = '0;
         end
      endcase
   end

   assign mul_prod  = mul_coef * mul_err;
   assign head_base = restart_ff ? '0 : heading_ff;
   assign head_sum  = {head_base[HEAD_W-1], head_base}
                    + {{(HEAD_W+1-DEL_W){rprod_ff[RPROD_W-1]}},
                       rprod_ff[RPROD_W-1:hhip_pkg::PERIOD_FRAC]};
   assign drive_sum = {{(SHIFT_W-SUMX_W){acc_ff[ACC_W-1]}},
                       acc_ff[ACC_W-1:hhip_pkg::COEF_FRAC+hhip_pkg::DEG_FRAC]}
                    + {{(SHIFT_W-DRIVE_W){last_drive_ff[DRIVE_W-1]}}, last_drive_ff};
   assign dr_sum = {2'b00, cfg.base_duty_right}
                 + {{(DSUM_W-DRIVE_W){drive_ff[DRIVE_W-1]}}, drive_ff};
   assign dl_sum = {2'b00, cfg.base_duty_left}
                 - {{(DSUM_W-DRIVE_W){drive_ff[DRIVE_W-1]}}, drive_ff};

   assign rsp_busy = rsp_valid_ff && !rsp_ch.ready;

   always_comb begin
      rprod_in      = rprod_ff;
      restart_in    = restart_ff;
      heading_in    = heading_ff;
      last_drive_in = last_drive_ff;
      err_prev_in   = err_prev_ff;
      err_prev2_in  = err_prev2_ff;
      acc_in        = acc_ff;
      drive_in      = drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      duty_right_in = duty_right_ff;
      duty_left_in  = duty_left_ff;
      needs_turn_in = needs_turn_ff;
      turn_ccw_in   = turn_ccw_ff;
      turn_deg_in   = turn_deg_ff;

      if (cmd.load) begin
         rprod_in   = rate_full[RPROD_W-1:0];
         restart_in = restart;
      end

      if (cmd.head_upd) begin
         // Saturate the heading to the signed 32 bit range.
         if (head_sum[HEAD_W] != head_sum[HEAD_W-1]) begin
            heading_in = head_sum[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}}
                                          : {1'b0, {(HEAD_W-1){1'b1}}};
         end else begin
            heading_in = head_sum[HEAD_W-1:0];
         end
         if (restart_ff) begin
            last_drive_in = '0;
            err_prev_in   = '0;
            err_prev2_in  = '0;
         end
      end

      if (cmd.mul_en) begin
         acc_in = ((cmd.mul_sel == hhip_pkg::MUL_NOW) ? '0 : acc_ff)
                + {{(ACC_W-PROD_W){mul_prod[PROD_W-1]}}, mul_prod};
      end

      if (cmd.sum_en) begin
         if (drive_sum > SHIFT_W'(hhip_pkg::DRIVE_LIMIT)) begin
            drive_in = hhip_pkg::DRIVE_LIMIT;
         end else if (drive_sum < -SHIFT_W'(hhip_pkg::DRIVE_LIMIT)) begin
            drive_in = -hhip_pkg::DRIVE_LIMIT;
         end else begin
            drive_in = drive_sum[DRIVE_W-1:0];
         end
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (turn) begin
            duty_right_in = cfg.base_duty_right;
            duty_left_in  = cfg.base_duty_left;
            needs_turn_in = 1'b1;
            turn_ccw_in   = !heading_ff[HEAD_W-1];
            turn_deg_in   = (|deg_full[HEAD_W-hhip_pkg::DEG_FRAC:DEG_W]) ? hhip_pkg::DEG_MAX
                                                              : deg_full[DEG_W-1:0];
            heading_in    = '0;
            last_drive_in = '0;
            err_prev_in   = '0;
            err_prev2_in  = '0;
         end else begin
            if (dr_sum[DSUM_W-1]) begin
               duty_right_in = '0;
            end else if (dr_sum[DUTY_W]) begin
               duty_right_in = hhip_pkg::DUTY_MAX;
            end else begin
               duty_right_in = dr_sum[DUTY_W-1:0];
            end
            if (dl_sum[DSUM_W-1]) begin
               duty_left_in = '0;
            end else if (dl_sum[DUTY_W]) begin
               duty_left_in = hhip_pkg::DUTY_MAX;
            end else begin
               duty_left_in = dl_sum[DUTY_W-1:0];
            end
            needs_turn_in = 1'b0;
            turn_ccw_in   = 1'b0;
            turn_deg_in   = '0;
            last_drive_in = drive_ff;
            err_prev2_in  = err_prev_ff;
            err_prev_in   = err_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff    <= '0;
         last_drive_ff <= '0;
         err_prev_ff   <= '0;
         err_prev2_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heading_ff    <= heading_in;
         last_drive_ff <= last_drive_in;
         err_prev_ff   <= err_prev_in;
         err_prev2_ff  <= err_prev2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rprod_ff      <= rprod_in;
      restart_ff    <= restart_in;
      acc_ff        <= acc_in;
      drive_ff      <= drive_in;
      duty_right_ff <= duty_right_in;
      duty_left_ff  <= duty_left_in;
      needs_turn_ff <= needs_turn_in;
      turn_ccw_ff   <= turn_ccw_in;
      turn_deg_ff   <= turn_deg_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.duty_right   = duty_right_ff;
   assign rsp_ch.duty_left    = duty_left_ff;
   assign rsp_ch.needs_turn   = needs_turn_ff;
   assign rsp_ch.turn_ccw     = turn_ccw_ff;
   assign rsp_ch.turn_degrees = turn_deg_ff;

   // A posted result is visible on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("posted result not presented");

   // The stored drive never leaves the clamp range.
   assert property (@(posedge clock) disable iff (reset)
      (last_drive_ff <= hhip_pkg::DRIVE_LIMIT) && (last_drive_ff >= -hhip_pkg::DRIVE_LIMIT))
      else $error("stored drive outside clamp range");

   // A turn request always resets the track state.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && turn) |=> (heading_ff == '0) && (err_prev_ff == '0))
      else $error("turn request did not clear the heading track");

endmodule

@@ tb/heading_hold_incremental_pid_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the heading-hold incremental PID block.
// Depends on hhip_pkg, hhip_req_if, hhip_rsp_if and heading_hold_incremental_pid.

module heading_hold_incremental_pid_tb;
   import hhip_pkg::*;

   // Result fields in the order of the result channel.
   typedef struct packed {
      logic [DUTY_W-1:0] duty_right;
      logic [DUTY_W-1:0] duty_left;
      logic              needs_turn;
      logic              turn_ccw;
      logic [DEG_W-1:0]  turn_degrees;
   } steer_type;

   // Limits of the control law. Heading and errors are in 1/256 degree.
   localparam longint TURN_MAG   = longint'(10) <<< DEG_FRAC;
   localparam longint DRIVE_MAX  = 4000;
   localparam longint DUTY_TOP   = 65535;
   localparam longint HEAD_MAX   = (longint'(1) <<< 31) - 1;
   localparam longint HEAD_MIN   = -(longint'(1) <<< 31);
   localparam int     PHASES     = 11;
   localparam int     PHASE_LEN  = 80;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_DAT_W-1:0] csr_wdata;

   hhip_req_if req_ch ();
   hhip_rsp_if rsp_ch ();

   heading_hold_incremental_pid uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // Our own copy of the registers and of the tracking state. Both are updated
   // at the clock edge where the write or the item is accepted, so every
   // prediction uses exactly what the block sees.
   cfg_type cfg_model;
   longint  heading_acc;
   longint  drive_prev;
   longint  err_last;
   longint  err_last2;

   // Duty pairs and turn requests that are still owed by the block, oldest first.
   steer_type pending_steer[$];

   // Idling knobs: each side draws a wait of 0..max cycles before every item.
   // A max of zero gives back-to-back traffic on that side.
   int src_gap_max;
   int rsp_gap_max;
   // One long receiver hold-off, consumed by the result process.
   int rsp_hold;

   int failures;
   int samples_sent;
   int turns_seen;
   int configs_loaded;

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic longint limit(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic void clear_tracking();
      heading_acc = 0;
      drive_prev  = 0;
      err_last    = 0;
      err_last2   = 0;
   endfunction

   function automatic cfg_type reset_cfg();
      cfg_type c;
      c.coef_now        = '0;
      c.coef_prev       = '0;
      c.coef_prev2      = '0;
      c.rate_offset     = '0;
      c.sample_period   = PERIOD_RESET;
      c.base_duty_right = BASE_RIGHT_RESET;
      c.base_duty_left  = BASE_LEFT_RESET;
      return c;
   endfunction

   // Works out the duty pair or turn request for one gyro sample and advances
   // the tracking state the same way the block does.
   function automatic steer_type predict_steer(input logic signed [RATE_W-1:0] rate,
                                               input logic restart);
      longint    diff;
      longint    step;
      longint    err_now;
      longint    mag;
      longint    acc;
      longint    drive;
      steer_type s;

      if (restart)
         clear_tracking();

      // Offset-corrected rate times the Q0.16 period, floored to 1/256 degree.
      diff = longint'(rate) - longint'($signed(cfg_model.rate_offset));
      step = (diff * longint'(cfg_model.sample_period)) >>> PERIOD_FRAC;
      heading_acc = limit(heading_acc + step, HEAD_MIN, HEAD_MAX);

      err_now = -heading_acc;
      mag = (err_now < 0) ? -err_now : err_now;
      s = '0;

      if (mag >= TURN_MAG) begin
         // Turn request: base duties pass through and the history is dropped.
         s.duty_right   = cfg_model.base_duty_right;
         s.duty_left    = cfg_model.base_duty_left;
         s.needs_turn   = 1'b1;
         s.turn_ccw     = (err_now < 0);
         s.turn_degrees = DEG_W'(limit(mag >>> DEG_FRAC, 0, longint'(DEG_MAX)));
         clear_tracking();
         return s;
      end

      // Velocity form: the three Q16.16 products are summed exactly, then
      // floored to whole duty counts and added to the previous action.
      acc = longint'($signed(cfg_model.coef_now)) * err_now
          + longint'($signed(cfg_model.coef_prev)) * err_last
          + longint'($signed(cfg_model.coef_prev2)) * err_last2;
      drive = limit(drive_prev + (acc >>> (COEF_FRAC + DEG_FRAC)), -DRIVE_MAX, DRIVE_MAX);

      s.duty_right = DUTY_W'(limit(longint'(cfg_model.base_duty_right) + drive, 0, DUTY_TOP));
      s.duty_left  = DUTY_W'(limit(longint'(cfg_model.base_duty_left) - drive, 0, DUTY_TOP));

      drive_prev = drive;
      err_last2  = err_last;
      err_last   = err_now;
      return s;
   endfunction

   // Offers one sample after a random gap and waits until the block takes it.
   // Valid is only dropped when a gap follows, so back-to-back items keep it high.
   task automatic send_sample(input logic signed [RATE_W-1:0] rate, input logic restart);
      int gap;
      gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.yaw_rate <= rate;
      req_ch.restart  <= restart;
      do @(posedge clock); while (!req_ch.ready);
      pending_steer.push_back(predict_steer(rate, restart));
      samples_sent++;
   endtask

   // Stops offering items and waits until every owed result has come back.
   // After this the block is idle and registers may be rewritten.
   task automatic pause_sender();
      req_ch.valid <= 1'b0;
      while (pending_steer.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all seven registers in consecutive cycles. Only called while idle.
   task automatic load_config(input cfg_type c);
      write_reg(REG_COEF_NOW,    c.coef_now);
      write_reg(REG_COEF_PREV,   c.coef_prev);
      write_reg(REG_COEF_PREV2,  c.coef_prev2);
      write_reg(REG_RATE_OFFSET, {{(CSR_DAT_W - RATE_W){c.rate_offset[RATE_W-1]}},
                                  c.rate_offset});
      write_reg(REG_PERIOD,      CSR_DAT_W'(c.sample_period));
      write_reg(REG_BASE_RIGHT,  CSR_DAT_W'(c.base_duty_right));
      write_reg(REG_BASE_LEFT,   CSR_DAT_W'(c.base_duty_left));
      csr_we <= 1'b0;
      cfg_model = c;
      configs_loaded++;
   endtask

   function automatic logic signed [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         // Moderate gains of up to 300 duty counts per degree either way.
         default: return int'($urandom_range(0, 600 * 65536)) - 300 * 65536;
      endcase
   endfunction

   function automatic logic [DUTY_W-1:0] random_base();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return DUTY_MAX;
         2: return DUTY_W'($urandom);
         default: return DUTY_W'($urandom_range(8000, 16000));
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.coef_now   = random_coef();
      c.coef_prev  = random_coef();
      c.coef_prev2 = random_coef();
      case ($urandom_range(0, 4))
         0: c.rate_offset = 16'sh8000;
         1: c.rate_offset = 16'sh7FFF;
         2: c.rate_offset = RATE_W'($urandom);
         default: c.rate_offset = RATE_W'(int'($urandom_range(0, 400)) - 200);
      endcase
      case ($urandom_range(0, 4))
         0: c.sample_period = '0;
         1: c.sample_period = 16'hFFFF;
         2: c.sample_period = HALF_W'($urandom);
         default: c.sample_period = HALF_W'($urandom_range(600, 2600));
      endcase
      c.base_duty_right = random_base();
      c.base_duty_left  = random_base();
      return c;
   endfunction

   // Most samples sit near the configured offset so the heading drifts slowly
   // and the PID runs for many steps; the rest are full-scale kicks and noise
   // that push the heading into turn requests.
   function automatic logic signed [RATE_W-1:0] random_rate();
      int v;
      case ($urandom_range(0, 9))
         0: return RATE_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: begin
            v = int'($signed(cfg_model.rate_offset)) + int'($urandom_range(0, 3000)) - 1500;
            return RATE_W'(limit(longint'(v), -32768, 32767));
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // Result side: stalls for a random number of cycles (or one long hold-off
   // when asked), then takes one result and checks it against the oldest
   // prediction.
   initial begin
      steer_type want;
      int        stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_steer.size() == 0) begin
            $error("result item arrived with no sample outstanding");
            failures++;
         end else begin
            want = pending_steer.pop_front();
            compare_field("duty_right",   int'(want.duty_right),   int'(rsp_ch.duty_right));
            compare_field("duty_left",    int'(want.duty_left),    int'(rsp_ch.duty_left));
            compare_field("needs_turn",   int'(want.needs_turn),   int'(rsp_ch.needs_turn));
            compare_field("turn_ccw",     int'(want.turn_ccw),     int'(rsp_ch.turn_ccw));
            compare_field("turn_degrees", int'(want.turn_degrees),
                          int'(rsp_ch.turn_degrees));
            if (want.needs_turn)
               turns_seen++;
         end
      end
   end

   // Reset values: zero gains, so the duties sit at the base values until the
   // heading reaches ten degrees. Full-scale rates in both directions give a
   // counterclockwise and then a clockwise turn request.
   task automatic test_reset_defaults();
      repeat (4) send_sample(16'sh7FFF, 1'b0);
      repeat (4) send_sample(16'sh8000, 1'b0);
      pause_sender();
   endtask

   // With a zero sample period the heading never moves, whatever the rate.
   task automatic test_zero_period();
      cfg_type c;
      c = reset_cfg();
      c.sample_period = '0;
      c.coef_now      = 32'sd100 <<< COEF_FRAC;
      load_config(c);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      pause_sender();
   endtask

   // Extreme gains drive the action into its clamp, and bases at the ends of
   // the duty range push both duties into saturation, first one way, then the
   // other. The second sample of each pair also exercises the history terms.
   task automatic test_duty_saturation();
      cfg_type c;
      c = reset_cfg();
      c.coef_now        = 32'h7FFF_FFFF;
      c.coef_prev       = 32'h8000_0000;
      c.coef_prev2      = 32'h8000_0000;
      c.base_duty_right = DUTY_MAX;
      c.base_duty_left  = '0;
      load_config(c);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b0);
      pause_sender();
      c.base_duty_right = '0;
      c.base_duty_left  = DUTY_MAX;
      load_config(c);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh0000, 1'b0);
      pause_sender();
   endtask

   // Offset and rate at opposite extremes with the longest period give the
   // biggest single heading step, i.e. the largest turn size that can occur.
   // A rate equal to the offset then leaves the cleared heading at zero.
   task automatic test_large_step();
      cfg_type c;
      c = reset_cfg();
      c.sample_period = 16'hFFFF;
      c.rate_offset   = 16'sh8000;
      load_config(c);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      pause_sender();
      c.rate_offset = 16'sh7FFF;
      load_config(c);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      pause_sender();
   endtask

   // Random register settings, each held for a run of samples with its own
   // idling pattern on both sides. Restarts come now and then.
   task automatic test_random_traffic();
      for (int p = 0; p < PHASES; p++) begin
         load_config(random_cfg());
         src_gap_max = $urandom_range(0, 1) ? 15 : 0;
         rsp_gap_max = $urandom_range(0, 1) ? 15 : 0;
         for (int i = 0; i < PHASE_LEN; i++)
            send_sample(random_rate(), $urandom_range(0, 15) == 0);
         pause_sender();
      end
   endtask

   // The receiver holds off for a long stretch while samples are offered back
   // to back, so the output register and the final step fill up and the
   // block has to stall its input.
   task automatic test_backpressure();
      src_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold    = 150;
      for (int i = 0; i < 30; i++)
         send_sample(random_rate(), 1'b0);
      pause_sender();
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_idx      = '0;
      csr_wdata    = '0;
      req_ch.valid    = 1'b0;
      req_ch.yaw_rate = '0;
      req_ch.restart  = 1'b0;
      src_gap_max  = 15;
      rsp_gap_max  = 15;
      rsp_hold     = 0;
      failures     = 0;
      samples_sent = 0;
      turns_seen   = 0;
      configs_loaded = 0;
      cfg_model    = reset_cfg();
      clear_tracking();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_period();
      test_duty_saturation();
      test_large_step();
      test_random_traffic();
      test_backpressure();

      // Everything owed has arrived; allow a few more cycles so a stray extra
      // result would still be caught by the result process.
      repeat (20) @(posedge clock);

      $display("Run covered %0d gyro samples under %0d register settings,", samples_sent,
               configs_loaded + 1);
      $display("including %0d turn requests, duty saturation and a long output stall.",
               turns_seen);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
